>>> src/hds_pkg.sv
// Package with the constants and types shared by the heat diffusion stencil block.
package hds_pkg;

    localparam int MAX_GRID = 1024;
    localparam int VALUE_BITS = 32;
    localparam int COL_BITS = $clog2(MAX_GRID);
    localparam int SIZE_BITS = 11;
    localparam int COEF_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam int SUM_BITS = VALUE_BITS + 4;
    localparam int PROD_BITS = SUM_BITS + COEF_BITS + 1;
    localparam int FRAC_BITS = 16;
    localparam int DELTA_BITS = PROD_BITS - FRAC_BITS;
    localparam int TOTAL_BITS = DELTA_BITS + 1;

    localparam logic [SIZE_BITS-1:0] MIN_GRID_SIZE = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0] MAX_GRID_SIZE = SIZE_BITS'(MAX_GRID);
    localparam logic [SIZE_BITS-1:0] GRID_SIZE_RESET = SIZE_BITS'(1024);
    localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(15729);

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_COEF = 1'b1;

    typedef struct packed {
        logic [COL_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } cell_tag_t;

endpackage

>>> src/hds_row_ram.sv
// Single-port row store with read-first behavior and registered read data.
module hds_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

>>> src/heat_diffusion_stencil_sweep_top.sv
// Top level of the five-point heat diffusion stencil over a raster-ordered grid.
// A result passes through the stage 1, stage 2, stage 3 and output registers before it is presented.
// Throughput: one word per cycle while item_ready is high, set by one access per row store bank per accepted word.
// Reset: counters, bank select and valid bits clear; configuration returns to size 1024, k 15729.
// The row stores are not cleared; their entries are written before they are read in a frame.
module heat_diffusion_stencil_sweep_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic signed [hds_pkg::VALUE_BITS-1:0] temperature,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [hds_pkg::VALUE_BITS-1:0] new_temperature,
    output logic [hds_pkg::COL_BITS-1:0]          cell_row,
    output logic [hds_pkg::COL_BITS-1:0]          cell_col,
    output logic                                  last_of_frame
);
    import hds_pkg::*;

    logic [SIZE_BITS-1:0] grid_size_reg;
    logic [COEF_BITS-1:0] coef_reg;
    logic [COL_BITS-1:0]  row_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic                 bank_sel_reg;

    logic [SIZE_BITS-1:0] n_eff;
    logic [SIZE_BITS-1:0] n_last;
    logic                 row_end;
    logic                 frame_end;
    logic                 accept;
    logic                 produce;

    logic [VALUE_BITS-1:0] rd0;
    logic [VALUE_BITS-1:0] rd1;

    logic                         s1_valid_reg;
    logic                         s1_produce_reg;
    logic                         s1_sel_reg;
    logic signed [VALUE_BITS-1:0] s1_cell_reg;
    cell_tag_t                    s1_tag_reg;
    logic                         s1_ready;
    logic                         s1_leave;

    logic signed [VALUE_BITS-1:0] pm1_reg;
    logic signed [VALUE_BITS-1:0] pm2_reg;
    logic signed [VALUE_BITS-1:0] nm1_reg;
    logic signed [VALUE_BITS-1:0] south_reg;
    logic signed [VALUE_BITS-1:0] prev_rd;
    logic signed [VALUE_BITS-1:0] older_rd;
    logic signed [SUM_BITS-1:0]   sum_next;

    logic                         s2_valid_reg;
    logic signed [SUM_BITS-1:0]   s2_sum_reg;
    logic signed [VALUE_BITS-1:0] s2_t_reg;
    cell_tag_t                    s2_tag_reg;
    logic                         s2_ready;
    logic signed [PROD_BITS-1:0]  prod_next;

    logic                         s3_valid_reg;
    logic signed [PROD_BITS-1:0]  s3_prod_reg;
    logic signed [VALUE_BITS-1:0] s3_t_reg;
    cell_tag_t                    s3_tag_reg;
    logic                         s3_ready;
    logic signed [PROD_BITS-1:0]  rounded;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [TOTAL_BITS-1:0] total;
    logic signed [VALUE_BITS-1:0] sat_next;

    logic                         result_valid_reg;
    logic signed [VALUE_BITS-1:0] result_value_reg;
    cell_tag_t                    result_tag_reg;
    logic                         out_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
            coef_reg      <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_SIZE: grid_size_reg <= cfg_data[SIZE_BITS-1:0];
                REG_DIFF_COEF: coef_reg <= cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (grid_size_reg < MIN_GRID_SIZE)
        begin
            n_eff = MIN_GRID_SIZE;
        end
        else if (grid_size_reg > MAX_GRID_SIZE)
        begin
            n_eff = MAX_GRID_SIZE;
        end
        else
        begin
            n_eff = grid_size_reg;
        end
        n_last = n_eff - SIZE_BITS'(1);
    end

    assign row_end   = SIZE_BITS'(col_reg) >= n_last;
    assign frame_end = SIZE_BITS'(row_reg) >= n_last;
    assign produce   = (row_reg >= COL_BITS'(2)) && (col_reg >= COL_BITS'(2));

    // Ready chain through the pipeline.
    assign out_ready  = !result_valid_reg || result_ready;
    assign s3_ready   = !s3_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || !s1_produce_reg || s2_ready;
    assign s1_leave   = s1_valid_reg && s1_ready;
    assign item_ready = s1_ready;
    assign accept     = item_valid && item_ready;

    // Raster position and row store bank select.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            bank_sel_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_reg      <= '0;
                row_reg      <= frame_end ? '0 : row_reg + COL_BITS'(1);
                bank_sel_reg <= !bank_sel_reg;
            end
            else
            begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // The bank named by bank_sel_reg holds the older row and takes the incoming word.
    hds_row_ram #(
        .DEPTH (MAX_GRID),
        .WIDTH (VALUE_BITS)
    ) u_bank0 (
        .clk   (clk),
        .en    (accept),
        .we    (accept && !bank_sel_reg),
        .addr  (col_reg),
        .wdata (temperature),
        .rdata (rd0)
    );

    hds_row_ram #(
        .DEPTH (MAX_GRID),
        .WIDTH (VALUE_BITS)
    ) u_bank1 (
        .clk   (clk),
        .en    (accept),
        .we    (accept && bank_sel_reg),
        .addr  (col_reg),
        .wdata (temperature),
        .rdata (rd1)
    );

    // Stage 1: row store data arrives; gather the neighborhood.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_produce_reg  <= produce;
            s1_sel_reg      <= bank_sel_reg;
            s1_cell_reg     <= temperature;
            s1_tag_reg.row  <= row_reg - COL_BITS'(1);
            s1_tag_reg.col  <= col_reg - COL_BITS'(1);
            s1_tag_reg.last <= row_end && frame_end;
        end
    end

    assign prev_rd  = s1_sel_reg ? $signed(rd0) : $signed(rd1);
    assign older_rd = s1_sel_reg ? $signed(rd1) : $signed(rd0);

    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            pm1_reg   <= prev_rd;
            pm2_reg   <= pm1_reg;
            nm1_reg   <= older_rd;
            south_reg <= s1_cell_reg;
        end
    end

    assign sum_next = SUM_BITS'(nm1_reg) + SUM_BITS'(south_reg) + SUM_BITS'(pm2_reg)
                    + SUM_BITS'(prev_rd) - (SUM_BITS'(pm1_reg) <<< 2);

    // Stage 2: weight the Laplacian by k.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg && s1_produce_reg)
        begin
            s2_sum_reg <= sum_next;
            s2_t_reg   <= pm1_reg;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    assign prod_next = PROD_BITS'(s2_sum_reg) * PROD_BITS'($signed({1'b0, coef_reg}));

    // Stage 3: round, add to the center value and saturate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_prod_reg <= prod_next;
            s3_t_reg    <= s2_t_reg;
            s3_tag_reg  <= s2_tag_reg;
        end
    end

    always_comb
    begin
        rounded = s3_prod_reg + PROD_BITS'(1 << (FRAC_BITS - 1));
        delta   = rounded[PROD_BITS-1:FRAC_BITS];
        total   = TOTAL_BITS'(delta) + TOTAL_BITS'(s3_t_reg);
        if (total[TOTAL_BITS-1:VALUE_BITS-1] == '0
            || total[TOTAL_BITS-1:VALUE_BITS-1] == '1)
        begin
            sat_next = total[VALUE_BITS-1:0];
        end
        else if (total[TOTAL_BITS-1])
        begin
            sat_next = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_next = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            result_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            result_value_reg <= sat_next;
            result_tag_reg   <= s3_tag_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign new_temperature = result_value_reg;
    assign cell_row        = result_tag_reg.row;
    assign cell_col        = result_tag_reg.col;
    assign last_of_frame   = result_tag_reg.last;

    // An interior cell never lies on the top row or left column.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cell_row != '0) && (cell_col != '0))
        else $error("result reported for a halo cell");

    // Finishing a row swaps the roles of the two row store banks.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end |=> bank_sel_reg != $past(bank_sel_reg))
        else $error("bank select did not toggle at row end");

    // A stalled middle stage keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_ready |=> s2_valid_reg && $stable(s2_sum_reg))
        else $error("stage 2 word lost under stall");

endmodule

>>> dv/hds_checker.sv
// Checker that predicts the stencil updates from accepted words and compares them with the results.
`timescale 1ns / 1ps
module hds_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  item_valid,
    input  logic                                  item_ready,
    input  logic signed [hds_pkg::VALUE_BITS-1:0] temperature,
    input  logic                                  result_valid,
    input  logic                                  result_ready,
    input  logic signed [hds_pkg::VALUE_BITS-1:0] new_temperature,
    input  logic [hds_pkg::COL_BITS-1:0]          cell_row,
    input  logic [hds_pkg::COL_BITS-1:0]          cell_col,
    input  logic                                  last_of_frame,
    output int                                    fail_count,
    output int                                    outstanding
);
    import hds_pkg::*;

    localparam longint TEMP_CEIL = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint TEMP_FLOOR = -TEMP_CEIL - 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        cell_tag_t             tag;
    } cell_update_t;

    cell_update_t         pending_updates[$];
    cell_update_t         oldest;
    longint               line_bank[2][MAX_GRID];
    bit                   older_bank;
    longint               west_cell;
    int unsigned          next_row;
    int unsigned          next_col;
    logic [SIZE_BITS-1:0] grid_size_reg;
    logic [COEF_BITS-1:0] coef_reg;

    task automatic diffuse_cell(input longint word_value);
        int unsigned side;
        int unsigned r;
        int unsigned c;
        bit          row_end;
        bit          frame_end;
        bit          above;
        longint      centre;
        longint      laplace;
        longint      delta;
        longint      updated;
        cell_update_t upd;
        if (grid_size_reg < MIN_GRID_SIZE)
            side = MIN_GRID_SIZE;
        else if (grid_size_reg > MAX_GRID_SIZE)
            side = MAX_GRID_SIZE;
        else
            side = grid_size_reg;
        r = next_row;
        c = next_col;
        row_end = c >= side - 1;
        frame_end = r >= side - 1;
        above = ~older_bank;
        if (r >= 2 && c >= 2)
        begin
            centre = line_bank[above][c-1];
            laplace = line_bank[older_bank][c-1] + west_cell + line_bank[above][c-2]
                      + line_bank[above][c] - 4 * centre;
            delta = (laplace * longint'(coef_reg) + 64'sd32768) >>> 16;
            updated = centre + delta;
            if (updated > TEMP_CEIL)
                updated = TEMP_CEIL;
            else if (updated < TEMP_FLOOR)
                updated = TEMP_FLOOR;
            upd.value = updated[VALUE_BITS-1:0];
            upd.tag.row = COL_BITS'(r - 1);
            upd.tag.col = COL_BITS'(c - 1);
            upd.tag.last = row_end && frame_end;
            pending_updates.push_back(upd);
        end
        // The north entry of column c-1 is used up, so it takes the current row.
        if (c >= 1)
            line_bank[older_bank][c-1] = west_cell;
        west_cell = word_value;
        if (row_end)
        begin
            line_bank[older_bank][c] = word_value;
            older_bank = ~older_bank;
            next_col = 0;
            next_row = frame_end ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (line_bank[b, i])
                line_bank[b][i] = 0;
            pending_updates.delete();
            older_bank = 1'b0;
            west_cell = 0;
            next_row = 0;
            next_col = 0;
            grid_size_reg = GRID_SIZE_RESET;
            coef_reg = COEF_RESET;
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_updates.size() == 0)
                begin
                    $error("result word with no expected word waiting: row %0d col %0d",
                           cell_row, cell_col);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_updates.pop_front();
                    if (new_temperature !== oldest.value)
                    begin
                        $error("new_temperature: expected %0d, actual %0d",
                               $signed(oldest.value), new_temperature);
                        fail_count++;
                    end
                    if (cell_row !== oldest.tag.row)
                    begin
                        $error("cell_row: expected %0d, actual %0d", oldest.tag.row, cell_row);
                        fail_count++;
                    end
                    if (cell_col !== oldest.tag.col)
                    begin
                        $error("cell_col: expected %0d, actual %0d", oldest.tag.col, cell_col);
                        fail_count++;
                    end
                    if (last_of_frame !== oldest.tag.last)
                    begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               oldest.tag.last, last_of_frame);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_SIZE)
                    grid_size_reg = cfg_data[SIZE_BITS-1:0];
                else if (cfg_index == REG_DIFF_COEF)
                    coef_reg = cfg_data[COEF_BITS-1:0];
            end
            if (item_valid && item_ready)
                diffuse_cell(longint'(temperature));
            outstanding <= pending_updates.size();
        end
    end

endmodule

>>> dv/tb_heat_diffusion_stencil_sweep_top.sv
// Testbench top that drives grid words and configuration into the stencil block and gives the verdict.
`timescale 1ns / 1ps
module tb_heat_diffusion_stencil_sweep_top;
    import hds_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 550;
    localparam int HOLD_SIDE = 10;
    localparam logic signed [VALUE_BITS-1:0] TEMP_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] TEMP_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum {FULL_RANGE, NEAR_ZERO, EXTREMES} temp_style_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    logic                          item_valid = 1'b0;
    logic                          item_ready;
    logic signed [VALUE_BITS-1:0]  temperature = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic signed [VALUE_BITS-1:0]  new_temperature;
    logic [COL_BITS-1:0]           cell_row;
    logic [COL_BITS-1:0]           cell_col;
    logic                          last_of_frame;
    int                            fail_count;
    int                            outstanding;
    int                            cycle_count;
    bit                            steady = 1'b1;
    bit                            hold_request = 1'b0;

    heat_diffusion_stencil_sweep_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .temperature     (temperature),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .new_temperature (new_temperature),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .last_of_frame   (last_of_frame)
    );

    hds_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .temperature     (temperature),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .new_temperature (new_temperature),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .last_of_frame   (last_of_frame),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("heat_diffusion_stencil_sweep_top: mismatch");
        $finish;
    end

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    function automatic logic signed [VALUE_BITS-1:0] pick_temperature(input temp_style_t style);
        logic [31:0] bits;
        bits = $urandom;
        case (style)
            NEAR_ZERO: return {{(VALUE_BITS-20){bits[19]}}, bits[19:0]};
            EXTREMES:
                case (bits[31:30])
                    2'd0: return TEMP_MAX;
                    2'd1: return TEMP_MIN;
                    2'd2: return bits[0] ? '1 : '0;
                    default: return bits;
                endcase
            default: return bits;
        endcase
    endfunction

    task automatic send_word(input logic signed [VALUE_BITS-1:0] value);
        if (!steady && $urandom_range(99) < 15)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        temperature <= value;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic send_words(input int count, input temp_style_t style);
        repeat (count) send_word(pick_temperature(style));
    endtask

    // One 3x3 grid whose single interior cell sees the given neighbors.
    task automatic send_cross(input logic signed [VALUE_BITS-1:0] north, west, centre, east,
                              south);
        send_word(pick_temperature(FULL_RANGE));
        send_word(north);
        send_word(pick_temperature(FULL_RANGE));
        send_word(west);
        send_word(centre);
        send_word(east);
        send_word(pick_temperature(FULL_RANGE));
        send_word(south);
        send_word(pick_temperature(FULL_RANGE));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                   words_sent;
        int                   phase;
        int                   side;
        int                   frames;
        int unsigned          pick;
        logic [SIZE_BITS-1:0] size_pick;
        logic [COEF_BITS-1:0] coef_pick;
        temp_style_t          style;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full-width row at the reset configuration; shrinking the grid mid-row then
        // ends that row at once and closes the frame after one short row.
        send_words(MAX_GRID + 3, FULL_RANGE);
        drain();
        write_register(REG_GRID_SIZE, CFG_DATA_BITS'(0));
        send_words(4, FULL_RANGE);
        drain();
        steady = 1'b0;

        write_register(REG_DIFF_COEF, '1);
        write_register(REG_GRID_SIZE, CFG_DATA_BITS'(1));
        send_cross(TEMP_MAX, TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MAX);
        send_cross(TEMP_MIN, TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MIN);
        drain();
        // Half-way products round up, toward plus infinity for negative sums too.
        write_register(REG_DIFF_COEF, CFG_DATA_BITS'(32768));
        write_register(REG_GRID_SIZE, CFG_DATA_BITS'(2));
        send_cross(1, 0, 0, 0, 0);
        send_cross(-1, 0, 0, 0, 0);
        send_cross(0, 0, 3, 0, 0);
        drain();
        write_register(REG_DIFF_COEF, '0);
        send_cross(pick_temperature(EXTREMES), pick_temperature(EXTREMES),
                   pick_temperature(EXTREMES), pick_temperature(EXTREMES),
                   pick_temperature(EXTREMES));
        drain();

        // The output side is held off while a whole grid keeps streaming in.
        write_register(REG_GRID_SIZE, CFG_DATA_BITS'(HOLD_SIDE));
        write_register(REG_DIFF_COEF, CFG_DATA_BITS'($urandom));
        hold_request = 1'b1;
        send_words(HOLD_SIDE * HOLD_SIDE, NEAR_ZERO);
        drain();

        words_sent = 0;
        phase = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            steady = (phase % 4 == 3);
            pick = $urandom_range(99);
            if (pick < 70)
                size_pick = SIZE_BITS'($urandom_range(10, 3));
            else if (pick < 90)
                size_pick = SIZE_BITS'($urandom_range(24, 11));
            else
                size_pick = SIZE_BITS'($urandom_range(2, 0));
            side = (size_pick < MIN_GRID_SIZE) ? int'(MIN_GRID_SIZE) : int'(size_pick);
            pick = $urandom_range(99);
            if (pick < 10)
                coef_pick = '0;
            else if (pick < 20)
                coef_pick = '1;
            else
                coef_pick = COEF_BITS'($urandom);
            if ($urandom_range(1) == 1)
            begin
                write_register(REG_GRID_SIZE, {5'($urandom), size_pick});
                write_register(REG_DIFF_COEF, coef_pick);
            end
            else
            begin
                write_register(REG_DIFF_COEF, coef_pick);
                write_register(REG_GRID_SIZE, {5'($urandom), size_pick});
            end
            frames = $urandom_range(2, 1);
            repeat (frames)
            begin
                style = temp_style_t'($urandom_range(2, 0));
                send_words(side * side, style);
            end
            words_sent += frames * side * side;
            phase++;
            drain();
        end

        if (fail_count == 0)
            $display("heat_diffusion_stencil_sweep_top: match");
        else
            $display("heat_diffusion_stencil_sweep_top: mismatch");
        $finish;
    end

endmodule
